### sv/cpsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsd_pkg
// Shared types, constants and register codes of the phi streak detector.
// ----------------------------------------------------------------------------
package cpsd_pkg;

	// grid geometry
	localparam int ETA_BINS   = 24;
	localparam int PHI_BINS   = 64;
	localparam int ETA_W      = (ETA_BINS > 1) ? $clog2(ETA_BINS) : 1;
	localparam int PHI_W      = (PHI_BINS > 1) ? $clog2(PHI_BINS) : 1;
	localparam int GRID_DEPTH = ETA_BINS * PHI_BINS;
	localparam int GRID_AW    = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;

	// tower flag word
	localparam int FLAG_W         = 2;
	localparam int FLAG_SEED_BIT  = 0;
	localparam int FLAG_QUIET_BIT = 1;

	localparam logic [7:0] GOOD_STATUS = 8'd1;

	// per-phi counts
	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// configuration port
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic signed [15:0] SEED_MIN_RST   = 16'sd1280;
	localparam logic signed [15:0] NBR_MAX_RST    = 16'sd256;
	localparam logic [CNT_W-1:0]   STREAK_THR_RST = 6'd5;

	typedef enum logic [1:0] {
		REG_SEED_MIN   = 2'd0,
		REG_NBR_MAX    = 2'd1,
		REG_STREAK_THR = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [4:0]         eta_bin;
		logic [5:0]         phi_bin;
		logic signed [15:0] tower_energy;
		logic [7:0]         status_code;
		logic               last_tower;
	} tower_in_t;

	typedef struct packed {
		logic             streak_found;
		logic [CNT_W-1:0] longest_count;
	} streak_out_t;

	// scan sequencer states
	typedef enum logic [2:0] {
		SC_IDLE,
		SC_CENTER,
		SC_UP,
		SC_DOWN,
		SC_EVAL,
		SC_PHI,
		SC_WRAP,
		SC_DONE
	} scan_state_t;

	// scan unit status toward the top level
	typedef struct packed {
		logic             idle;
		logic             done;
		logic [CNT_W-1:0] longest;
	} scan_stat_t;

endpackage

### sv/cpsd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cpsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/cpsd_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpsd_scan
// Grid scan sequencer with one shared saturating adder and max compare.
// ----------------------------------------------------------------------------
module cpsd_scan import cpsd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               ack,
	output logic [GRID_AW-1:0] raddr,
	input  logic [FLAG_W-1:0]  rdata,
	output scan_stat_t         stat
);

	scan_state_t state_q, state_d;

	logic [PHI_W-1:0]   p_q;
	logic [ETA_W-1:0]   e_q;
	logic [GRID_AW-1:0] base_q;
	logic               seed_q;
	logic               quiet_up_q;
	logic [CNT_W-1:0]   s_cur_q;
	logic [CNT_W-1:0]   s_prev_q;
	logic [CNT_W-1:0]   s_first_q;
	logic [CNT_W-1:0]   max_q;

	logic             e_last;
	logic             p_last;
	logic [PHI_W-1:0] p_up;
	logic [PHI_W-1:0] p_dn;
	logic             hit;
	logic [CNT_W-1:0] add_a;
	logic [CNT_W-1:0] add_b;
	logic [CNT_W:0]   sum_w;
	logic [CNT_W-1:0] sat;
	logic             gt;

	assign e_last = (e_q == ETA_W'(ETA_BINS - 1));
	assign p_last = (p_q == PHI_W'(PHI_BINS - 1));
	assign p_up   = p_last ? '0 : p_q + 1'b1;
	assign p_dn   = (p_q == '0) ? PHI_W'(PHI_BINS - 1) : p_q - 1'b1;

	// rdata in SC_EVAL holds the phi-1 neighbor flags
	assign hit = seed_q & quiet_up_q & rdata[FLAG_QUIET_BIT];

	// shared saturating adder and max compare
	always_comb begin
		case (state_q)
			SC_EVAL: begin
				add_a = s_cur_q;
				add_b = CNT_W'(hit);
			end
			SC_PHI: begin
				add_a = s_cur_q;
				add_b = s_prev_q;
			end
			SC_WRAP: begin
				add_a = s_first_q;
				add_b = s_prev_q;
			end
			default: begin
				add_a = '0;
				add_b = '0;
			end
		endcase
	end

	assign sum_w = {1'b0, add_a} + {1'b0, add_b};
	assign sat   = sum_w[CNT_W] ? COUNT_MAX : sum_w[CNT_W-1:0];
	assign gt    = (sat > max_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			SC_IDLE:   if (start) state_d = SC_CENTER;
			SC_CENTER: state_d = SC_UP;
			SC_UP:     state_d = SC_DOWN;
			SC_DOWN:   state_d = SC_EVAL;
			SC_EVAL:   state_d = e_last ? SC_PHI : SC_CENTER;
			SC_PHI:    state_d = p_last ? SC_WRAP : SC_CENTER;
			SC_WRAP:   state_d = SC_DONE;
			SC_DONE:   if (ack) state_d = SC_IDLE;
			default:   state_d = SC_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		case (state_q)
			SC_UP:   raddr = base_q + GRID_AW'(p_up);
			SC_DOWN: raddr = base_q + GRID_AW'(p_dn);
			default: raddr = base_q + GRID_AW'(p_q);
		endcase
		stat.idle    = (state_q == SC_IDLE);
		stat.done    = (state_q == SC_DONE);
		stat.longest = max_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
			p_q     <= '0;
			e_q     <= '0;
			base_q  <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				SC_IDLE: begin
					if (start) begin
						p_q    <= '0;
						e_q    <= '0;
						base_q <= '0;
					end
				end
				SC_EVAL: begin
					// advance to the next eta row, or back to row zero
					if (e_last) begin
						e_q    <= '0;
						base_q <= '0;
					end else begin
						e_q    <= e_q + 1'b1;
						base_q <= base_q + GRID_AW'(PHI_BINS);
					end
				end
				SC_PHI: begin
					p_q <= p_up;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				if (start) begin
					s_cur_q <= '0;
					max_q   <= '0;
				end
			end
			SC_UP:   seed_q     <= rdata[FLAG_SEED_BIT];
			SC_DOWN: quiet_up_q <= rdata[FLAG_QUIET_BIT];
			SC_EVAL: s_cur_q    <= sat;
			SC_PHI: begin
				// phi zero pairs with the last phi bin at the end
				if (p_q == '0) begin
					s_first_q <= s_cur_q;
				end else if (gt) begin
					max_q <= sat;
				end
				s_prev_q <= s_cur_q;
				s_cur_q  <= '0;
			end
			SC_WRAP: begin
				if (gt) begin
					max_q <= sat;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == SC_IDLE)
		else $error("scan start while busy");

	a_eval_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SC_EVAL |-> $past(state_q) == SC_DOWN)
		else $error("evaluation without neighbor reads");

	a_wrap_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SC_WRAP |-> (p_q == '0 && e_q == '0 && base_q == '0))
		else $error("scan counters not rewound at wrap");

	a_max_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != SC_IDLE && $past(state_q) != SC_IDLE) |-> max_q >= $past(max_q))
		else $error("longest count decreased during scan");
`endif

endmodule

### sv/calo_phi_streak_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calo_phi_streak_detector
// Loads a tower grid as seed/quiet flags and counts phi streaks per event.
// ----------------------------------------------------------------------------
//  port group | direction | beat content
//  -----------+-----------+-----------------------------------------------
//  in_*       | in        | tower_in_t: one tower per beat, last_tower ends event
//  out_*      | out       | streak_out_t: one beat per event
//  p*         | in/out    | APB registers: 0x0 seed min, 0x4 nbr max, 0x8 thr
//
//  A beat with last_tower starts the grid scan, which reads three flag
//  entries per tower through the single read port of the flag RAM.
//  in_ready is low during the scan and while the result waits for the
//  output register. The output register frees as soon as its beat is taken.
//  Reset clears control state and the registers; the flag RAM is not cleared.
// ----------------------------------------------------------------------------
module calo_phi_streak_detector import cpsd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tower_in_t          in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output streak_out_t        out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic signed [15:0] seed_min_q;
	logic signed [15:0] nbr_max_q;
	logic [CNT_W-1:0]   thr_q;

	logic               out_valid_q;
	streak_out_t        out_q;

	logic               in_fire;
	logic               in_range;
	logic               good;
	logic [FLAG_W-1:0]  wflags;
	logic [GRID_AW-1:0] waddr;
	logic [GRID_AW-1:0] raddr;
	logic [FLAG_W-1:0]  rdata;
	logic               start;
	logic               ack;
	logic               cfg_wr;
	reg_idx_t           reg_idx;
	scan_stat_t         stat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_min_q <= SEED_MIN_RST;
			nbr_max_q  <= NBR_MAX_RST;
			thr_q      <= STREAK_THR_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_SEED_MIN:   seed_min_q <= pwdata[15:0];
				REG_NBR_MAX:    nbr_max_q  <= pwdata[15:0];
				REG_STREAK_THR: thr_q      <= pwdata[CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SEED_MIN:   prdata = PDATA_W'(seed_min_q);
			REG_NBR_MAX:    prdata = PDATA_W'(nbr_max_q);
			REG_STREAK_THR: prdata = PDATA_W'(thr_q);
			default:        prdata = '0;
		endcase
	end

	// tower load: reduce to flags with the registers as they stand now
	assign in_ready = stat.idle;
	assign in_fire  = in_valid & in_ready;
	assign in_range = (int'(in_data.eta_bin) < ETA_BINS) && (int'(in_data.phi_bin) < PHI_BINS);
	assign good     = (in_data.status_code == GOOD_STATUS);

	assign wflags[FLAG_SEED_BIT]  = good && (in_data.tower_energy >= seed_min_q);
	assign wflags[FLAG_QUIET_BIT] = good && (in_data.tower_energy <= nbr_max_q);

	assign waddr = GRID_AW'(in_data.eta_bin) * GRID_AW'(PHI_BINS) + GRID_AW'(in_data.phi_bin);
	assign start = in_fire & in_data.last_tower;

	cpsd_ram #(
		.WIDTH (FLAG_W),
		.DEPTH (GRID_DEPTH)
	) u_flags (
		.clk   (clk),
		.we    (in_fire & in_range),
		.waddr (waddr),
		.wdata (wflags),
		.raddr (raddr),
		.rdata (rdata)
	);

	cpsd_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.ack    (ack),
		.raddr  (raddr),
		.rdata  (rdata),
		.stat   (stat)
	);

	// hand the scan result to the output register once it is free
	assign ack = stat.done & (~out_valid_q | out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ack) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			out_q.streak_found  <= (stat.longest > thr_q);
			out_q.longest_count <= stat.longest;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
